### rtl/ifp_pkg.sv
// Shared types, character codes and classification functions for the
// infix-to-postfix converter. No dependencies.
package ifp_pkg;

    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_UNMATCHED  = 3'd1,
        STATUS_UNCLOSED   = 3'd2,
        STATUS_OVERFLOW   = 3'd3,
        STATUS_INVALID    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_OPER  = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_FLUSH = 2'd2
    } mode_t;

    // Request from the sequencer to the result buffer.
    typedef struct packed {
        logic       produce;
        logic       finish;
        logic       done_flag;
        logic [7:0] sym;
        status_t    status;
    } res_req_t;

    // Occupancy seen by the sequencer.
    typedef struct packed {
        logic pend_valid;
        logic out_free;
    } res_stat_t;

    function automatic logic [1:0] precedence(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            8'h2B, 8'h2D: p = 2'd1;
            8'h2A, 8'h2F: p = 2'd2;
            8'h21, 8'h5E: p = 2'd3;
            default:      p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

endpackage

### rtl/ifp_stack.sv
// Operator stack storage: one write port and one registered read port.
// Depends on nothing but its depth parameter.
module ifp_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                     wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
    output logic [7:0]                     rd_data
);

    logic [7:0] mem [STACK_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ifp_out.sv
// Result buffer: a pending slot that holds the newest result until it is
// known whether it ends the run, and the output register. Uses ifp_pkg.
module ifp_out
    import ifp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  res_req_t    req,
    output res_stat_t   stat,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_symbol, [10:8] status, rest zero
    output logic        m_axis_tlast,  // last_of_run
    output logic        m_axis_tuser   // expression_done
);

    logic       pend_valid_reg;
    logic [7:0] pend_sym_reg;
    status_t    pend_status_reg;
    logic       out_valid_reg;
    logic [7:0] out_sym_reg;
    status_t    out_status_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic       out_free;
    logic       move;

    assign out_free = !out_valid_reg || m_axis_tready;
    // The pending result moves on when a newer one replaces it or when the
    // run is closed.
    assign move = pend_valid_reg && out_free && (req.produce || req.finish);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (req.produce) begin
                pend_valid_reg <= 1'b1;
            end else if (req.finish && move) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_sym_reg    <= pend_sym_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= req.finish;
            out_done_reg   <= req.finish && req.done_flag;
        end
        if (req.produce) begin
            pend_sym_reg    <= req.sym;
            pend_status_reg <= req.status;
        end
    end

    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_status_reg, out_sym_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

endmodule

### rtl/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: the sequencer that drives
// the operator stack and the result buffer. Uses ifp_pkg, ifp_stack, ifp_out.
//
// The block takes one ASCII character per input transfer (s_axis_tlast marks
// the last character of an expression) and emits postfix characters on the
// output stream, one per transfer, with status, last-of-run (m_axis_tlast)
// and expression-done (m_axis_tuser). Items are handled one at a time: the
// input is ready only while the sequencer is idle. A letter or an invalid
// character passes through ST_TAIL, ST_ERR and ST_FIN before the input is
// ready again, and an opening bracket first through ST_PUSH. An operator or
// a closing bracket pops the stack through ST_POP_RD and ST_POP_CK for every
// entry, because the single stack read port has a registered read: one
// state addresses the top entry and the other compares it. The pops end
// when they reach an empty stack or a stacked entry (an operator of lower
// precedence or the matching bracket); an operator then goes through
// ST_PUSH, and a closing bracket with no opener goes straight to ST_ERR. An
// end-flagged character without an error adds a flush of the stack through
// the same pop states, ended by the same rule, plus a terminator result in
// ST_FIN when nothing was emitted. A stalled output stream holds the
// sequencer whenever a new result has to leave the buffer. No clearing pass
// is needed after reset.
module infix_to_postfix_converter
    import ifp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
    input  logic        s_axis_tlast,  // end_of_expression
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_symbol, [10:8] status, rest zero
    output logic        m_axis_tlast,  // last_of_run
    output logic        m_axis_tuser   // expression_done
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_POP_RD = 7'b0000010,
        ST_POP_CK = 7'b0000100,
        ST_PUSH   = 7'b0001000,
        ST_TAIL   = 7'b0010000,
        ST_ERR    = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  sym_reg, sym_next;
    logic        end_reg, end_next;
    status_t     err_reg, err_next;
    mode_t       mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic        skip_reg, skip_next;

    res_req_t    req;
    res_stat_t   stat;
    logic        can_produce;
    logic        wr_en;
    logic        rd_en;
    logic [7:0]  top;
    logic [CW-1:0] count_dec;

    assign can_produce = !stat.pend_valid || stat.out_free;
    assign count_dec   = count_reg - CW'(1);
    assign s_axis_tready = (state_reg == ST_IDLE);

    ifp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (sym_reg),
        .rd_en   (rd_en),
        .rd_addr (count_dec[AW-1:0]),
        .rd_data (top)
    );

    ifp_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_comb begin
        state_next = state_reg;
        sym_next   = sym_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        req        = '{produce: 1'b0, finish: 1'b0, done_flag: 1'b0,
                       sym: 8'h00, status: STATUS_OK};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    sym_next  = s_axis_tdata;
                    end_next  = s_axis_tlast;
                    err_next  = STATUS_OK;
                    mode_next = MODE_OPER;
                    if (skip_reg) begin
                        // The rest of a failed expression is dropped; its end
                        // character re-arms the block.
                        if (s_axis_tlast) begin
                            skip_next = 1'b0;
                        end
                    end else if (is_letter(s_axis_tdata)) begin
                        // The pending slot is always empty here, so the operand
                        // goes straight in.
                        req.produce = 1'b1;
                        req.sym     = s_axis_tdata;
                        state_next  = ST_TAIL;
                    end else if (precedence(s_axis_tdata) != 2'd0) begin
                        state_next = ST_POP_RD;
                    end else if (s_axis_tdata == CHAR_OPEN) begin
                        state_next = ST_PUSH;
                    end else if (s_axis_tdata == CHAR_CLOSE) begin
                        mode_next  = MODE_CLOSE;
                        state_next = ST_POP_RD;
                    end else begin
                        err_next   = STATUS_INVALID;
                        state_next = ST_TAIL;
                    end
                end
            end

            ST_POP_RD: begin
                if (count_reg == '0) begin
                    case (mode_reg)
                        MODE_OPER:  state_next = ST_PUSH;
                        MODE_CLOSE: begin
                            err_next   = STATUS_UNMATCHED;
                            state_next = ST_ERR;
                        end
                        default:    state_next = ST_ERR;
                    endcase
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_POP_CK;
                end
            end

            ST_POP_CK: begin
                case (mode_reg)
                    MODE_OPER: begin
                        // An opening bracket has precedence zero and stops
                        // the pops on its own.
                        if (precedence(top) >= precedence(sym_reg)) begin
                            if (can_produce) begin
                                req.produce = 1'b1;
                                req.sym     = top;
                                count_next  = count_dec;
                                state_next  = ST_POP_RD;
                            end
                        end else begin
                            state_next = ST_PUSH;
                        end
                    end
                    MODE_CLOSE: begin
                        if (top != CHAR_OPEN) begin
                            if (can_produce) begin
                                req.produce = 1'b1;
                                req.sym     = top;
                                count_next  = count_dec;
                                state_next  = ST_POP_RD;
                            end
                        end else begin
                            count_next = count_dec;
                            state_next = ST_TAIL;
                        end
                    end
                    default: begin
                        if (top == CHAR_OPEN) begin
                            err_next   = STATUS_UNCLOSED;
                            state_next = ST_ERR;
                        end else if (can_produce) begin
                            req.produce = 1'b1;
                            req.sym     = top;
                            count_next  = count_dec;
                            state_next  = ST_POP_RD;
                        end
                    end
                endcase
            end

            ST_PUSH: begin
                if (count_reg >= CW'(STACK_DEPTH)) begin
                    err_next = STATUS_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_TAIL;
            end

            ST_TAIL: begin
                // An end character without error flushes the whole stack.
                if (err_reg == STATUS_OK && end_reg && mode_reg != MODE_FLUSH) begin
                    mode_next  = MODE_FLUSH;
                    state_next = ST_POP_RD;
                end else begin
                    state_next = ST_ERR;
                end
            end

            ST_ERR: begin
                if (err_reg != STATUS_OK) begin
                    if (can_produce) begin
                        req.produce = 1'b1;
                        req.sym     = 8'h00;
                        req.status  = err_reg;
                        count_next  = '0;
                        skip_next   = !end_reg;
                        state_next  = ST_FIN;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                if (!stat.pend_valid) begin
                    // Nothing was produced: an end character still gets a
                    // terminator result, any other character gets none.
                    if (end_reg) begin
                        req.produce = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (stat.out_free) begin
                    req.finish    = 1'b1;
                    req.done_flag = end_reg || (err_reg != STATUS_OK);
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            skip_reg  <= 1'b0;
            mode_reg  <= MODE_OPER;
            err_reg   <= STATUS_OK;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
            mode_reg  <= mode_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
        end_reg <= end_next;
    end

endmodule

### test/infix_to_postfix_converter_tb.sv
// Self-checking testbench for the infix-to-postfix converter.
// Uses ifp_pkg for status codes and bracket and letter character codes,
// and drives infix_to_postfix_converter through its two stream ports.
module infix_to_postfix_converter_tb
    import ifp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = 16;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    // Longest correct pause without any transfer is the long receiver hold
    // below, so the watchdog allows several times that.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    // A full flush pops every stacked entry through the pop states.
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_ITEMS   = 200;
    localparam int QUIET_ITEMS    = 60;

    // Operator and space characters; brackets and letter bounds come from the package.
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] sym;
        status_t    status;
        logic       last_of_run;
        logic       expr_done;
    } postfix_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] symbol
    logic        s_axis_tlast;   // end_of_expression
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] out_symbol, [10:8] status, [15:11] zero
    logic        m_axis_tlast;   // last_of_run
    logic        m_axis_tuser;   // expression_done

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state: our own copy of the operator stack and the skip flag.
    logic [7:0]    op_stack [0:STACK_DEPTH-1];
    int            op_depth = 0;
    logic          skip_rest = 1'b0;
    postfix_item_t postfix_expect [$];
    int            taken_symbols = 0;   // input transfers that were not skipped
    int            fail_count = 0;
    int            stall_cycles = 0;

    // Stimulus control shared between the test tasks and the receiver.
    logic          idle_enable;
    int            hold_request;
    logic [7:0]    pending_chars [$];

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Precedence of an operator character; zero for anything else.
    function automatic int op_rank(input logic [7:0] c);
        case (c)
            CHAR_PLUS, CHAR_MINUS: return 1;
            CHAR_STAR, CHAR_SLASH: return 2;
            CHAR_BANG, CHAR_CARET: return 3;
            default:               return 0;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

    function automatic postfix_item_t plain_result(input logic [7:0] sym, input status_t st);
        postfix_item_t r;
        r.sym         = sym;
        r.status      = st;
        r.last_of_run = 1'b0;
        r.expr_done   = 1'b0;
        return r;
    endfunction

    // Shunting-yard step for one accepted character. The results it causes
    // are collected locally so that the flags of the final one can be set
    // before they join the queue of expected results.
    function automatic void shunt_symbol(input logic [7:0] sym, input logic eoe);
        postfix_item_t run_items [0:STACK_DEPTH+1];
        int            n;
        int            rank;
        status_t       err;
        postfix_item_t tail;
        n    = 0;
        err  = STATUS_OK;
        rank = op_rank(sym);

        // After an error everything up to and including the end-flagged
        // character vanishes without a result.
        if (skip_rest) begin
            if (eoe)
                skip_rest = 1'b0;
            return;
        end
        taken_symbols++;

        if (is_alpha(sym)) begin
            run_items[n] = plain_result(sym, STATUS_OK);
            n++;
        end else if (rank != 0) begin
            while (op_depth > 0 && op_rank(op_stack[op_depth-1]) >= rank) begin
                op_depth--;
                run_items[n] = plain_result(op_stack[op_depth], STATUS_OK);
                n++;
            end
            if (op_depth >= STACK_DEPTH) begin
                err = STATUS_OVERFLOW;
            end else begin
                op_stack[op_depth] = sym;
                op_depth++;
            end
        end else if (sym == CHAR_OPEN) begin
            if (op_depth >= STACK_DEPTH) begin
                err = STATUS_OVERFLOW;
            end else begin
                op_stack[op_depth] = sym;
                op_depth++;
            end
        end else if (sym == CHAR_CLOSE) begin
            while (op_depth > 0 && op_stack[op_depth-1] != CHAR_OPEN) begin
                op_depth--;
                run_items[n] = plain_result(op_stack[op_depth], STATUS_OK);
                n++;
            end
            if (op_depth == 0)
                err = STATUS_UNMATCHED;
            else
                op_depth--;
        end else begin
            err = STATUS_INVALID;
        end

        // End of expression: flush, and an opening bracket met on the way
        // turns into an unclosed-bracket error.
        if (err == STATUS_OK && eoe) begin
            while (op_depth > 0 && err == STATUS_OK) begin
                op_depth--;
                if (op_stack[op_depth] == CHAR_OPEN) begin
                    err = STATUS_UNCLOSED;
                end else begin
                    run_items[n] = plain_result(op_stack[op_depth], STATUS_OK);
                    n++;
                end
            end
        end

        if (err != STATUS_OK) begin
            run_items[n] = plain_result(8'h00, err);
            n++;
            op_depth = 0;
            if (!eoe)
                skip_rest = 1'b1;
        end

        // An expression that ends with nothing to emit still gets a terminator.
        if (n == 0 && eoe) begin
            run_items[n] = plain_result(8'h00, STATUS_OK);
            n++;
        end

        if (n > 0) begin
            tail             = run_items[n-1];
            tail.last_of_run = 1'b1;
            tail.expr_done   = eoe || (err != STATUS_OK);
            run_items[n-1]   = tail;
        end
        for (int i = 0; i < n; i++)
            postfix_expect.push_back(run_items[i]);
    endfunction

    // Scoreboard: every accepted input feeds the predictor, and every
    // accepted result is compared with the oldest expectation. Both use the
    // values present just before the rising edge. Reports list each result
    // as symbol/status/last/done.
    always @(posedge aclk) begin
        postfix_item_t want;
        logic [4:0]    pad;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                shunt_symbol(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                pad = m_axis_tdata[15:11];
                if (postfix_expect.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected none, got %h/%0d/%b/%b",
                             $time, m_axis_tdata[7:0], m_axis_tdata[10:8],
                             m_axis_tlast, m_axis_tuser);
                end else begin
                    want = postfix_expect.pop_front();
                    if (m_axis_tdata[7:0] !== want.sym || m_axis_tdata[10:8] !== want.status ||
                        m_axis_tlast !== want.last_of_run || m_axis_tuser !== want.expr_done ||
                        pad !== 5'd0) begin
                        fail_count++;
                        $display("%0t: expected %h/%0d/%b/%b pad 0, got %h/%0d/%b/%b pad %h",
                                 $time, want.sym, want.status, want.last_of_run,
                                 want.expr_done, m_axis_tdata[7:0], m_axis_tdata[10:8],
                                 m_axis_tlast, m_axis_tuser, pad);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transfer.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: ready by default, with random stall bursts while idling is
    // enabled, and one long hold when a test requests it.
    initial begin
        int   burst;
        logic hold_taken;
        hold_taken    = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0 && !hold_taken) begin
                hold_taken    = 1'b1;
                m_axis_tready = 1'b0;
                repeat (hold_request) @(negedge aclk);
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                burst = $urandom_range(1, 9);
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Offers one character and returns at the falling edge after its
    // transfer. tvalid stays high into the next call unless a gap is taken.
    task automatic send_symbol(input logic [7:0] sym, input logic eoe);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = sym;
        s_axis_tlast  = eoe;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Sends a string as one expression, flagging its last character.
    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_symbol(text[i], i == text.len() - 1);
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
        return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 5))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_STAR;
            3:       return CHAR_SLASH;
            4:       return CHAR_BANG;
            default: return CHAR_CARET;
        endcase
    endfunction

    // Builds one expression into pending_chars. Most are well formed with
    // random letters, operators and nesting; a few nest deep enough to
    // overflow the stack, and some are damaged or plain garbage.
    function automatic void build_expression();
        int terms;
        int nest;
        int max_nest;
        int open_odds;
        int noise;
        int i;
        int k;
        pending_chars.delete();
        nest = 0;
        if ($urandom_range(0, 11) == 0) begin
            max_nest  = STACK_DEPTH + 1;
            open_odds = 3;
        end else begin
            max_nest  = $urandom_range(1, 4);
            open_odds = 1;
        end
        terms = $urandom_range(1, 7);
        for (i = 0; i < terms; i++) begin
            while (nest < max_nest && $urandom_range(0, 3) < open_odds) begin
                pending_chars.push_back(CHAR_OPEN);
                nest++;
            end
            pending_chars.push_back(random_letter());
            while (nest > 0 && $urandom_range(0, 2) == 0) begin
                pending_chars.push_back(CHAR_CLOSE);
                nest--;
            end
            if (i < terms - 1)
                pending_chars.push_back(random_operator());
        end
        while (nest > 0) begin
            pending_chars.push_back(CHAR_CLOSE);
            nest--;
        end

        noise = $urandom_range(0, 99);
        if (noise < 10) begin
            k = $urandom_range(0, pending_chars.size() - 1);
            pending_chars[k] = 8'($urandom_range(0, 255));
        end else if (noise < 15) begin
            pending_chars.push_back(CHAR_CLOSE);
        end else if (noise < 20) begin
            if (pending_chars.size() > 1)
                void'(pending_chars.pop_back());
        end else if (noise < 25) begin
            pending_chars.push_front(CHAR_OPEN);
        end else if (noise < 29) begin
            pending_chars.delete();
            k = $urandom_range(1, 6);
            for (i = 0; i < k; i++)
                pending_chars.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_expression();
        int i;
        build_expression();
        for (i = 0; i < pending_chars.size(); i++)
            send_symbol(pending_chars[i], i == pending_chars.size() - 1);
    endtask

    // Extreme letters, every operator, and brackets around a subexpression.
    task automatic test_operands_and_operators();
        send_text("Az");
        send_text("(a-b)*c^d/e!f+Z");
    endtask

    // Invalid codes: one mid-expression starts skipping up to the end flag,
    // one carrying the end flag errs without skipping.
    task automatic test_invalid_symbols();
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);
        send_symbol(CHAR_SPACE, 1'b1);
    endtask

    // A closing bracket with no opener, and an opener left at the end.
    task automatic test_bracket_errors();
        send_symbol(CHAR_CLOSE, 1'b1);
        send_symbol(CHAR_OPEN, 1'b1);
    endtask

    // An empty bracket pair at the end leaves nothing to emit.
    task automatic test_empty_result();
        send_text("()");
    endtask

    // Fill the stack exactly and drain it, then overflow it with an operator
    // push in mid-expression so that the rest is skipped.
    task automatic test_stack_limits();
        int i;
        for (i = 0; i < STACK_DEPTH; i++)
            send_symbol(CHAR_OPEN, 1'b0);
        send_symbol(CHAR_LOWER_A, 1'b0);
        for (i = 0; i < STACK_DEPTH; i++)
            send_symbol(CHAR_CLOSE, i == STACK_DEPTH - 1);
        for (i = 0; i < STACK_DEPTH - 1; i++)
            send_symbol(CHAR_OPEN, 1'b0);
        send_text("a+b*c)");
    endtask

    // The receiver holds off for a long stretch while characters keep
    // coming, so the block backs up and stops taking input.
    task automatic test_output_backpressure();
        hold_request = LONG_HOLD;
        repeat (4)
            send_expression();
    endtask

    task automatic test_random_expressions(input int count);
        int start;
        start = taken_symbols;
        while (taken_symbols - start < count)
            send_expression();
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        aresetn       = 1'b0;
        idle_enable   = 1'b1;
        hold_request  = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_operands_and_operators();
        test_invalid_symbols();
        test_bracket_errors();
        test_empty_result();
        test_stack_limits();
        test_output_backpressure();
        test_random_expressions(RANDOM_ITEMS - QUIET_ITEMS);
        // The closing stretch runs with both sides at full rate.
        idle_enable = 1'b0;
        test_random_expressions(QUIET_ITEMS);

        s_axis_tvalid = 1'b0;
        while (postfix_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
